// ===== rtl/lzssrw_pkg.sv =====
package lzssrw_pkg;

	localparam int MAX_WINDOW_BITS = 12;
	localparam int WIN_AW          = MAX_WINDOW_BITS;
	localparam int MAX_LEN_BITS    = 5;
	localparam int CNT_W           = 6;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 24;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BITS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_BYTE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd6;

	localparam logic [1:0] FILL_CONST   = 2'd0;
	localparam logic [1:0] FILL_SPARSE  = 2'd1;

	localparam logic [3:0]  RST_WINDOW_BITS  = 4'd12;
	localparam logic [2:0]  RST_LENGTH_BITS  = 3'd4;
	localparam logic [3:0]  RST_MIN_MATCH    = 4'd2;
	localparam logic [7:0]  RST_START_OFFSET = 8'd2;
	localparam logic [1:0]  RST_FILL_MODE    = FILL_CONST;
	localparam logic [7:0]  RST_FILL_BYTE    = 8'h20;
	localparam logic [23:0] RST_OUTPUT_LIMIT = 24'hffffff;

	localparam int RST_WB     = (12 > MAX_WINDOW_BITS) ? MAX_WINDOW_BITS : 12;
	localparam int RST_WP_INT = (2**RST_WB - 2**4 - 2) % (2**RST_WB);
	localparam logic [WIN_AW-1:0] RST_WRITE_POINTER = WIN_AW'(RST_WP_INT);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_entry_t;

	function automatic logic [WIN_AW-1:0] win_mask_f(input logic [3:0] wb);
		logic [WIN_AW-1:0] m;
		int eff;
		eff = (int'(wb) > MAX_WINDOW_BITS) ? MAX_WINDOW_BITS : int'(wb);
		for (int i = 0; i < WIN_AW; i++) begin
			m[i] = (i < eff);
		end
		return m;
	endfunction

	function automatic logic [MAX_LEN_BITS-1:0] len_mask_f(input logic [2:0] lb);
		logic [MAX_LEN_BITS-1:0] m;
		for (int i = 0; i < MAX_LEN_BITS; i++) begin
			m[i] = (i < int'(lb));
		end
		return m;
	endfunction

	function automatic logic [7:0] fill_value_f(input logic [1:0] mode, input logic [7:0] fbyte,
		input logic [WIN_AW-1:0] idx);
		logic [WIN_AW-1:0] sh;
		logic [7:0] v;
		sh = idx >> 3;
		case (mode)
			FILL_CONST:  v = fbyte;
			FILL_SPARSE: v = (idx[2:0] == 3'd6) ? sh[7:0] : 8'd0;
			default:     v = idx[7:0];
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/lzssrw_out_fifo.sv =====
module lzssrw_out_fifo
	import lzssrw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  out_entry_t push_entry,
	input  logic       pop,
	output out_entry_t head,
	output logic       not_empty,
	output logic [2:0] count
);

	out_entry_t  entry_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != 3'd0);
	assign count     = count_q;

endmodule

// ===== rtl/lzss_ring_window_decompressor_unit.sv =====
// Literal: accepted in idle, then written from the process state into the output FIFO; input stalled meanwhile.
// Reference: each byte is read from the window memory and registered before the output FIFO, one byte per cycle
// while the FIFO has room, from the single-port-read window memory; input stalled until the copy has drained.
// Stream start: the window memory is refilled one entry a cycle, all 4096 entries, first.
// Reset: the same fill of all 4096 entries with reset register values, input stalled meanwhile.
module lzss_ring_window_decompressor_unit
	import lzssrw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  first_of_stream,
	input  logic                  last_of_stream,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  last_of_run
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_PROC = 2'd2;
	localparam logic [1:0] ST_COPY = 2'd3;

	localparam logic [1:0] PH_FLAG  = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_HIGH  = 2'd2;

	logic [3:0]  window_bits_q;
	logic [2:0]  length_bits_q;
	logic [3:0]  min_match_q;
	logic [7:0]  start_offset_q;
	logic [1:0]  fill_mode_q;
	logic [7:0]  fill_byte_q;
	logic [23:0] output_limit_q;

	logic [1:0]        state_q;
	logic [1:0]        phase_q;
	logic [8:0]        flag_q;
	logic [7:0]        offset_low_q;
	logic [WIN_AW-1:0] wp_q;
	logic [23:0]       count_q;
	logic [CNT_W-1:0]  issue_left_q;
	logic [WIN_AW-1:0] fill_cnt_q;
	logic              proc_after_q;
	logic [1:0]        sweep_mode_q;
	logic [7:0]        sweep_byte_q;

	logic [7:0]        item_byte_q;
	logic              item_last_q;
	logic [WIN_AW-1:0] copy_addr_q;

	logic              valid_s1;
	logic              last_k_s1;
	logic              fwd_s1;
	logic [7:0]        fwd_data_s1;
	logic [7:0]        rd_data_s1;

	logic [7:0] window_mem [2**WIN_AW];

	logic [WIN_AW-1:0]       win_mask;
	logic [2:0]              lb;
	logic [MAX_LEN_BITS-1:0] len_mask;
	logic                    in_take;
	logic                    count_ok;
	logic                    is_lit;
	logic                    fifo_full;
	logic                    proc_wait;
	logic                    lit_emit;
	logic                    issue;
	logic                    copy_emit;
	logic                    emit;
	logic [7:0]              copy_data;
	out_entry_t              emit_entry;
	logic                    wr_en;
	logic [WIN_AW-1:0]       wr_addr;
	logic [7:0]              wr_data;
	logic                    fwd;
	logic [WIN_AW-1:0]       wp_init;
	logic [WIN_AW-1:0]       span;
	logic [15:0]             offs_full;
	logic [WIN_AW-1:0]       offs;
	logic [CNT_W-1:0]        copy_cnt;
	logic [8:0]              flag_next;
	logic [1:0]              phase_next;
	logic                    pop;
	out_entry_t              head;
	logic [2:0]              fifo_count;

	assign win_mask = win_mask_f(window_bits_q);
	assign lb       = (length_bits_q > 3'(MAX_LEN_BITS)) ? 3'(MAX_LEN_BITS) : length_bits_q;
	assign len_mask = len_mask_f(lb);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign count_ok = (count_q < output_limit_q);

	assign is_lit    = (phase_q == PH_TOKEN) && flag_q[0];
	assign fifo_full = (fifo_count == 3'd4);
	assign proc_wait = is_lit && fifo_full;
	assign lit_emit  = (state_q == ST_PROC) && is_lit && !fifo_full && count_ok;

	assign issue     = (state_q == ST_COPY) && (issue_left_q != '0)
		&& (({1'b0, fifo_count} + 4'(valid_s1)) <= 4'd2);
	assign copy_data = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign copy_emit = valid_s1 && count_ok;
	assign emit      = lit_emit || copy_emit;

	always_comb begin
		emit_entry.data = valid_s1 ? copy_data : item_byte_q;
		emit_entry.last = valid_s1 ? (last_k_s1 || ((count_q + 24'd1) >= output_limit_q)) : 1'b1;
	end

	always_comb begin
		if (state_q == ST_FILL) begin
			wr_en   = 1'b1;
			wr_addr = fill_cnt_q;
			wr_data = fill_value_f(sweep_mode_q, sweep_byte_q, fill_cnt_q);
		end else begin
			wr_en   = emit;
			wr_addr = wp_q & win_mask;
			wr_data = emit_entry.data;
		end
	end

	assign fwd = wr_en && (wr_addr == copy_addr_q);

	assign span      = WIN_AW'(1) << lb;
	assign wp_init   = (win_mask + WIN_AW'(1) - span - WIN_AW'(start_offset_q)) & win_mask;
	assign offs_full = {8'(item_byte_q >> lb), offset_low_q};
	assign offs      = WIN_AW'(offs_full) & win_mask;
	assign copy_cnt  = CNT_W'(item_byte_q[MAX_LEN_BITS-1:0] & len_mask) + CNT_W'(min_match_q)
		+ CNT_W'(1);
	assign flag_next  = flag_q >> 1;
	assign phase_next = (flag_next <= 9'd1) ? PH_FLAG : PH_TOKEN;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			window_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= window_mem[copy_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_bits_q  <= RST_WINDOW_BITS;
			length_bits_q  <= RST_LENGTH_BITS;
			min_match_q    <= RST_MIN_MATCH;
			start_offset_q <= RST_START_OFFSET;
			fill_mode_q    <= RST_FILL_MODE;
			fill_byte_q    <= RST_FILL_BYTE;
			output_limit_q <= RST_OUTPUT_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_BITS:  window_bits_q  <= cfg_data[3:0];
				REG_LENGTH_BITS:  length_bits_q  <= cfg_data[2:0];
				REG_MIN_MATCH:    min_match_q    <= cfg_data[3:0];
				REG_START_OFFSET: start_offset_q <= cfg_data[7:0];
				REG_FILL_MODE:    fill_mode_q    <= cfg_data[1:0];
				REG_FILL_BYTE:    fill_byte_q    <= cfg_data[7:0];
				REG_OUTPUT_LIMIT: output_limit_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_byte_q <= data_byte;
			item_last_q <= last_of_stream;
		end
		if ((state_q == ST_PROC) && (phase_q == PH_HIGH)) begin
			copy_addr_q <= offs;
		end else if (issue) begin
			copy_addr_q <= (copy_addr_q + WIN_AW'(1)) & win_mask;
		end
		last_k_s1   <= (issue_left_q == CNT_W'(1));
		fwd_s1      <= fwd;
		fwd_data_s1 <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			phase_q      <= PH_FLAG;
			flag_q       <= '0;
			offset_low_q <= '0;
			wp_q         <= RST_WRITE_POINTER;
			count_q      <= '0;
			issue_left_q <= '0;
			fill_cnt_q   <= '0;
			proc_after_q <= 1'b0;
			sweep_mode_q <= RST_FILL_MODE;
			sweep_byte_q <= RST_FILL_BYTE;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				issue_left_q <= issue_left_q - CNT_W'(1);
			end
			if (emit) begin
				wp_q    <= (wp_q + WIN_AW'(1)) & win_mask;
				count_q <= count_q + 24'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (first_of_stream) begin
							wp_q         <= wp_init;
							flag_q       <= '0;
							phase_q      <= PH_FLAG;
							offset_low_q <= '0;
							count_q      <= '0;
							sweep_mode_q <= fill_mode_q;
							sweep_byte_q <= fill_byte_q;
							fill_cnt_q   <= '0;
							proc_after_q <= 1'b1;
							state_q      <= ST_FILL;
						end else begin
							state_q <= ST_PROC;
						end
					end
				end
				ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + WIN_AW'(1);
					if (&fill_cnt_q) begin
						state_q <= proc_after_q ? ST_PROC : ST_IDLE;
					end
				end
				ST_PROC: begin
					if (!proc_wait) begin
						if (phase_q == PH_HIGH) begin
							issue_left_q <= copy_cnt;
							state_q      <= ST_COPY;
						end else begin
							state_q <= ST_IDLE;
						end
						if (item_last_q) begin
							phase_q      <= PH_FLAG;
							flag_q       <= '0;
							offset_low_q <= '0;
						end else begin
							case (phase_q)
								PH_TOKEN: begin
									if (flag_q[0]) begin
										flag_q  <= flag_next;
										phase_q <= phase_next;
									end else begin
										offset_low_q <= item_byte_q;
										phase_q      <= PH_HIGH;
									end
								end
								PH_HIGH: begin
									flag_q  <= flag_next;
									phase_q <= phase_next;
								end
								default: begin
									flag_q  <= {1'b1, item_byte_q};
									phase_q <= PH_TOKEN;
								end
							endcase
						end
					end
				end
				ST_COPY: begin
					if ((issue_left_q == '0) && !valid_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pop = out_valid && !out_stall;

	lzssrw_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (emit),
		.push_entry (emit_entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (out_valid),
		.count      (fifo_count)
	);

	assign out_byte    = head.data;
	assign last_of_run = head.last;

endmodule

// ===== rtl/lzssrw_checker.sv =====
module lzssrw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       first_of_stream,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// hold off the next transaction while the accepted byte is decoded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input transaction accepted while previous byte still in progress");

	// hold off input across the window refill at stream start
	a_busy_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && first_of_stream |=> ##1 in_stall)
		else $error("input accepted during window refill");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("stalled output transaction changed");

endmodule

bind lzss_ring_window_decompressor_unit lzssrw_checker u_checker (.*);

// ===== dv/lzss_ring_window_decompressor_unit_tb.sv =====
`timescale 1ns / 100ps

module lzss_ring_window_decompressor_unit_tb;
	import lzssrw_pkg::*;

	localparam int QUIET_CYCLES = (1 << WIN_AW) + 128;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 20;
	localparam int FIXED_SETTINGS = 7;
	localparam int DIRECTED_ROWS = 22;

	localparam logic [1:0] FILL_INDEX     = 2'd2;
	localparam logic [1:0] FILL_INDEX_ALT = 2'd3;

	typedef enum logic [1:0] {WANT_FLAGS, WANT_TOKEN, WANT_HIGH} token_phase_t;

	typedef struct packed {
		logic [3:0]  wbits;
		logic [2:0]  lbits;
		logic [3:0]  minm;
		logic [7:0]  soff;
		logic [1:0]  fmode;
		logic [7:0]  fbyte;
		logic [23:0] olimit;
	} decomp_cfg_t;

	typedef struct packed {
		logic [7:0] b;
		logic       sos;
		logic       eos;
		logic       typed;
		logic [5:0] n;
		logic [7:0] val;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte = 8'h00;
	logic                  first_of_stream = 1'b0;
	logic                  last_of_stream = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            out_byte;
	logic                  last_of_run;

	lzss_ring_window_decompressor_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.first_of_stream (first_of_stream),
		.last_of_stream  (last_of_stream),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.last_of_run     (last_of_run)
	);

	always #5 clk = ~clk;

	// decoder state as the block should hold it
	logic [7:0]        ring [0:(1 << WIN_AW)-1];
	logic [WIN_AW-1:0] wr_ptr;
	logic [8:0]        flag_sr;
	token_phase_t      tok_phase;
	logic [7:0]        off_lo;
	logic [23:0]       out_cnt;
	decomp_cfg_t       live_cfg;

	out_entry_t decoded_q[$];
	out_entry_t head;

	int send_idle = 7;
	int rcv_idle = 63;
	int mismatches = 0;
	int items_in = 0;
	int bytes_checked = 0;
	int stream_starts = 0;
	int settings_used = 0;

	decomp_cfg_t fixed_cfg [FIXED_SETTINGS] = '{
		'{4'd12, 3'd4, 4'd2,  8'd2,   FILL_CONST,     8'h20, 24'hffffff},
		'{4'd8,  3'd0, 4'd0,  8'd0,   FILL_SPARSE,    8'h00, 24'hffffff},
		'{4'd15, 3'd7, 4'd15, 8'd255, FILL_INDEX,     8'hff, 24'hffffff},
		'{4'd3,  3'd5, 4'd0,  8'd255, FILL_INDEX_ALT, 8'ha5, 24'd7},
		'{4'd0,  3'd1, 4'd15, 8'd128, FILL_CONST,     8'h5a, 24'hffffff},
		'{4'd10, 3'd3, 4'd7,  8'd17,  FILL_SPARSE,    8'h00, 24'd40},
		'{4'd9,  3'd6, 4'd1,  8'd255, FILL_CONST,     8'hc3, 24'd0}
	};

	dir_row_t dir_tab [DIRECTED_ROWS] = '{
		'{8'h01, 1'b1, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b1, 6'd1,  8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'h0f, 1'b0, 1'b0, 1'b1, 6'd18, 8'h20},
		'{8'hff, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'hf0, 1'b0, 1'b0, 1'b1, 6'd3,  8'h20},
		'{8'hee, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'hff, 1'b0, 1'b0, 1'b0, 6'd0,  8'h00},
		'{8'h12, 1'b0, 1'b1, 1'b1, 6'd0,  8'h00},
		'{8'hff, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'h80, 1'b0, 1'b0, 1'b1, 6'd1,  8'h80},
		'{8'h7f, 1'b0, 1'b0, 1'b1, 6'd1,  8'h7f},
		'{8'hff, 1'b0, 1'b0, 1'b1, 6'd1,  8'hff},
		'{8'h00, 1'b0, 1'b1, 1'b1, 6'd1,  8'h00},
		'{8'h00, 1'b1, 1'b1, 1'b1, 6'd0,  8'h00},
		'{8'h00, 1'b1, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b1, 6'd3,  8'h20},
		'{8'h55, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'h5a, 1'b0, 1'b0, 1'b1, 6'd13, 8'h20},
		'{8'hfd, 1'b0, 1'b0, 1'b1, 6'd0,  8'h00},
		'{8'hf5, 1'b0, 1'b1, 1'b0, 6'd0,  8'h00}
	};

	function automatic int ring_mask();
		int eff;
		eff = (live_cfg.wbits > MAX_WINDOW_BITS) ? MAX_WINDOW_BITS : int'(live_cfg.wbits);
		return (1 << eff) - 1;
	endfunction

	function automatic int len_width();
		return (live_cfg.lbits > MAX_LEN_BITS) ? MAX_LEN_BITS : int'(live_cfg.lbits);
	endfunction

	function automatic void flag_error(string msg);
		if (mismatches < 10)
			$display("%0t: %s", $time, msg);
		mismatches++;
	endfunction

	task automatic restart_stream();
		int m;
		m = ring_mask();
		for (int i = 0; i < (1 << WIN_AW); i++) begin
			case (live_cfg.fmode)
				FILL_CONST:  ring[i] = live_cfg.fbyte;
				FILL_SPARSE: ring[i] = ((i & 7) == 6) ? 8'(i >> 3) : 8'h00;
				default:     ring[i] = 8'(i);
			endcase
		end
		wr_ptr = WIN_AW'(((m + 1) - (1 << len_width()) - int'(live_cfg.soff)) & m);
		flag_sr = '0;
		tok_phase = WANT_FLAGS;
		off_lo = '0;
		out_cnt = '0;
	endtask

	task automatic emit_byte(input logic [7:0] c, ref out_entry_t res[$]);
		if (out_cnt >= live_cfg.olimit)
			return;
		res.push_back('{data: c, last: 1'b0});
		ring[int'(wr_ptr) & ring_mask()] = c;
		wr_ptr = WIN_AW'((int'(wr_ptr) + 1) & ring_mask());
		out_cnt++;
	endtask

	task automatic advance_token();
		flag_sr = flag_sr >> 1;
		tok_phase = (flag_sr <= 9'd1) ? WANT_FLAGS : WANT_TOKEN;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic sos, input logic eos,
		ref out_entry_t res[$]);
		int lb;
		int m;
		int offs;
		int cnt;
		res.delete();
		if (sos)
			restart_stream();
		case (tok_phase)
			WANT_TOKEN: begin
				if (flag_sr[0]) begin
					emit_byte(b, res);
					advance_token();
				end else begin
					off_lo = b;
					tok_phase = WANT_HIGH;
				end
			end
			WANT_HIGH: begin
				lb = len_width();
				m = ring_mask();
				offs = int'(off_lo) | ((int'(b) >> lb) << 8);
				cnt = (int'(b) & ((1 << lb) - 1)) + int'(live_cfg.minm) + 1;
				for (int k = 0; k < cnt; k++)
					emit_byte(ring[(offs + k) & m], res);
				advance_token();
			end
			default: begin
				flag_sr = {1'b1, b};
				tok_phase = WANT_TOKEN;
			end
		endcase
		if (eos) begin
			tok_phase = WANT_FLAGS;
			flag_sr = '0;
			off_lo = '0;
		end
		if (res.size() > 0)
			res[res.size()-1].last = 1'b1;
	endtask

	task automatic send_item(input logic [7:0] b, input logic sos, input logic eos,
		input logic typed, input int n, input logic [7:0] val);
		out_entry_t res[$];
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_of_stream <= sos;
		last_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		decode_byte(b, sos, eos, res);
		if (typed) begin
			res.delete();
			repeat (n) res.push_back('{data: val, last: 1'b0});
			if (res.size() > 0)
				res[res.size()-1].last = 1'b1;
		end
		foreach (res[i])
			decoded_q.push_back(res[i]);
		items_in++;
		if (sos)
			stream_starts++;
	endtask

	// well-formed token groups; references lean towards the write pointer for overlap
	task automatic send_stream(input int len, input bit sos, input bit close);
		logic [7:0] flags;
		int left;
		int lb;
		int d;
		left = len;
		while (left > 0) begin
			flags = 8'($urandom);
			send_item(flags, sos, close && left == 1, 1'b0, 0, 8'h00);
			sos = 1'b0;
			left--;
			for (int i = 0; i < 8 && left > 0; i++) begin
				if (flags[i]) begin
					send_item(8'($urandom), 1'b0, close && left == 1, 1'b0, 0, 8'h00);
					left--;
				end else begin
					lb = len_width();
					if ($urandom_range(1))
						d = int'(wr_ptr) - int'($urandom_range(4, 1));
					else
						d = int'($urandom);
					send_item(8'(d), 1'b0, close && left == 1, 1'b0, 0, 8'h00);
					left--;
					if (left > 0) begin
						send_item(8'(((d >> 8) << lb) | (int'($urandom) & ((1 << lb) - 1))),
							1'b0, close && left == 1, 1'b0, 0, 8'h00);
						left--;
					end
				end
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input decomp_cfg_t c);
		logic [CFG_IDX_W-1:0] idx;
		for (int i = 0; i <= int'(REG_OUTPUT_LIMIT); i++) begin
			idx = CFG_IDX_W'(i);
			cfg_write <= 1'b1;
			cfg_index <= idx;
			case (idx)
				REG_WINDOW_BITS:  cfg_data <= CFG_DATA_W'(c.wbits);
				REG_LENGTH_BITS:  cfg_data <= CFG_DATA_W'(c.lbits);
				REG_MIN_MATCH:    cfg_data <= CFG_DATA_W'(c.minm);
				REG_START_OFFSET: cfg_data <= CFG_DATA_W'(c.soff);
				REG_FILL_MODE:    cfg_data <= CFG_DATA_W'(c.fmode);
				REG_FILL_BYTE:    cfg_data <= CFG_DATA_W'(c.fbyte);
				REG_OUTPUT_LIMIT: cfg_data <= CFG_DATA_W'(c.olimit);
				default:          cfg_data <= '0;
			endcase
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		live_cfg = c;
		settings_used++;
	endtask

	task automatic run_phase(input decomp_cfg_t c, input int budget);
		int start_n;
		int len;
		bit sos;
		start_n = items_in;
		settle();
		apply_settings(c);
		sos = ($urandom_range(3) != 0);
		while (items_in - start_n < budget) begin
			if ($urandom_range(99) < 15) begin
				send_item(8'($urandom), $urandom_range(7) == 0, $urandom_range(3) == 0,
					1'b0, 0, 8'h00);
			end else begin
				len = $urandom_range(28, 3);
				if (len > budget - (items_in - start_n))
					len = budget - (items_in - start_n);
				send_stream(len, sos, (items_in - start_n + len < budget) || $urandom_range(1));
				sos = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h last %0b", out_byte, last_of_run));
			end else begin
				head = decoded_q.pop_front();
				if (out_byte !== head.data)
					flag_error($sformatf("out_byte expected %02h got %02h", head.data, out_byte));
				if (last_of_run !== head.last)
					flag_error($sformatf("last_of_run expected %0b got %0b",
						head.last, last_of_run));
			end
			bytes_checked++;
		end
		out_stall <= ($urandom_range(99) < rcv_idle);
	end

	initial begin
		decomp_cfg_t c;
		live_cfg = '{RST_WINDOW_BITS, RST_LENGTH_BITS, RST_MIN_MATCH, RST_START_OFFSET,
			RST_FILL_MODE, RST_FILL_BYTE, RST_OUTPUT_LIMIT};
		restart_stream();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r])
			send_item(dir_tab[r].b, dir_tab[r].sos, dir_tab[r].eos, dir_tab[r].typed,
				int'(dir_tab[r].n), dir_tab[r].val);

		for (int p = 0; p < PHASES; p++) begin
			if (p < FIXED_SETTINGS) begin
				c = fixed_cfg[p];
			end else begin
				c.wbits = 4'($urandom);
				c.lbits = 3'($urandom);
				c.minm = 4'($urandom);
				c.soff = 8'($urandom);
				c.fmode = 2'($urandom);
				c.fbyte = 8'($urandom);
				c.olimit = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(80));
			end
			if (p < 3) begin
				send_idle = 7;
				rcv_idle = 63;
			end else if (p < 6) begin
				send_idle = 63;
				rcv_idle = 7;
			end else begin
				send_idle = 0;
				rcv_idle = 0;
			end
			run_phase(c, PHASE_ITEMS);
		end

		settle();
		$display("%0d compressed bytes under %0d register settings, %0d stream starts",
			items_in, settings_used, stream_starts);
		$display("%0d decoded bytes compared, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
